>>> hdl/i2cmts_pkg.sv
package i2cmts_pkg;

  // Largest byte count kept for either part of a transaction
  localparam int MAX_COUNT_DEF = 255;

  // Bus engine status codes, compared on the upper five bits
  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
  localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_WBYTE = 2'd1,
    ACT_DONE  = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_SEND      = 3'd2,
    CMD_RECV_ACK  = 3'd3,
    CMD_RECV_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    RES_OK          = 3'd0,
    RES_START_FAIL  = 3'd1,
    RES_WADDR_NACK  = 3'd2,
    RES_RSTART_FAIL = 3'd3,
    RES_RADDR_NACK  = 3'd4,
    RES_EMPTY       = 3'd5
  } res_code_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_W_START = 3'd1,
    PH_W_ADDR  = 3'd2,
    PH_W_NEED  = 3'd3,
    PH_W_DATA  = 3'd4,
    PH_R_START = 3'd5,
    PH_R_ADDR  = 3'd6,
    PH_R_DATA  = 3'd7
  } phase_t;

  // One input item
  typedef struct packed {
    logic [7:0] rx_data;
    logic [7:0] status_code;
    logic [7:0] write_byte;
    logic       address_only;
    logic [7:0] read_count;
    logic [7:0] write_count;
    logic [6:0] target_address;
    logic [1:0] action;
  } item_t;

  // One result item
  typedef struct packed {
    logic [2:0] result_code;
    logic       done_res;
    logic       need_write_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
    logic [2:0] bus_command;
  } res_t;

endpackage

>>> hdl/i2cmts_core.sv
module i2cmts_core #(
  parameter int MAX_COUNT = i2cmts_pkg::MAX_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  i2cmts_pkg::item_t  item,
  output i2cmts_pkg::res_t   res
);
  import i2cmts_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] wleft_r, wleft_nxt;
  logic [7:0] rleft_r, rleft_nxt;
  logic       probe_r, probe_nxt;

  logic [7:0] status;
  logic [7:0] wcnt, rcnt;

  // Saturate the requested counts
  always_comb begin
    wcnt = item.write_count;
    rcnt = item.read_count;
    if (int'(item.write_count) > MAX_COUNT) wcnt = MAX_COUNT[7:0];
    if (int'(item.read_count) > MAX_COUNT) rcnt = MAX_COUNT[7:0];
  end

  assign status = item.status_code & STATUS_MASK;

  // Decide the bus command and next state for the current item
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    wleft_nxt = wleft_r;
    rleft_nxt = rleft_r;
    probe_nxt = probe_r;
    res       = '0;
    case (action_t'(item.action))
      ACT_BEGIN: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt  = item.target_address;
          wleft_nxt = wcnt;
          rleft_nxt = rcnt;
          probe_nxt = item.address_only;
          if (wcnt == 8'd0 && rcnt == 8'd0) begin
            res.done_res    = 1'b1;
            res.result_code = RES_EMPTY;
          end else begin
            res.bus_command = CMD_START;
            phase_nxt = (wcnt != 8'd0) ? PH_W_START : PH_R_START;
          end
        end
      end
      ACT_WBYTE: begin
        if (phase_r == PH_W_NEED) begin
          res.bus_command = CMD_SEND;
          res.tx_byte     = item.write_byte;
          wleft_nxt       = wleft_r - 8'd1;
          phase_nxt       = PH_W_DATA;
        end
      end
      ACT_DONE: begin
        case (phase_r)
          PH_W_START: begin
            if (status != ST_START) begin
              res.done_res    = 1'b1;
              res.result_code = RES_START_FAIL;
              phase_nxt       = PH_IDLE;
            end else begin
              res.bus_command = CMD_SEND;
              res.tx_byte     = {addr_r, 1'b0};
              phase_nxt       = PH_W_ADDR;
            end
          end
          PH_W_ADDR: begin
            if (status != ST_MT_SLA_ACK) begin
              res.bus_command = CMD_STOP;
              res.done_res    = 1'b1;
              res.result_code = RES_WADDR_NACK;
              phase_nxt       = PH_IDLE;
            end else if (probe_r) begin
              wleft_nxt = 8'd0;
              if (rleft_r != 8'd0) begin
                res.bus_command = CMD_START;
                phase_nxt       = PH_R_START;
              end else begin
                res.bus_command = CMD_STOP;
                res.done_res    = 1'b1;
                phase_nxt       = PH_IDLE;
              end
            end else begin
              res.need_write_byte = 1'b1;
              phase_nxt           = PH_W_NEED;
            end
          end
          PH_W_DATA: begin
            if (wleft_r != 8'd0) begin
              res.need_write_byte = 1'b1;
              phase_nxt           = PH_W_NEED;
            end else if (rleft_r != 8'd0) begin
              res.bus_command = CMD_START;
              phase_nxt       = PH_R_START;
            end else begin
              res.bus_command = CMD_STOP;
              res.done_res    = 1'b1;
              phase_nxt       = PH_IDLE;
            end
          end
          PH_R_START: begin
            if (status != ST_REP_START && status != ST_START) begin
              res.bus_command = CMD_STOP;
              res.done_res    = 1'b1;
              res.result_code = RES_RSTART_FAIL;
              phase_nxt       = PH_IDLE;
            end else begin
              res.bus_command = CMD_SEND;
              res.tx_byte     = {addr_r, 1'b1};
              phase_nxt       = PH_R_ADDR;
            end
          end
          PH_R_ADDR: begin
            if (status != ST_MR_SLA_ACK) begin
              res.bus_command = CMD_STOP;
              res.done_res    = 1'b1;
              res.result_code = RES_RADDR_NACK;
              phase_nxt       = PH_IDLE;
            end else begin
              res.bus_command = (rleft_r > 8'd1) ? CMD_RECV_ACK : CMD_RECV_NACK;
              rleft_nxt       = rleft_r - 8'd1;
              phase_nxt       = PH_R_DATA;
            end
          end
          PH_R_DATA: begin
            res.rx_byte  = item.rx_data;
            res.rx_valid = 1'b1;
            if (rleft_r != 8'd0) begin
              res.bus_command = (rleft_r > 8'd1) ? CMD_RECV_ACK : CMD_RECV_NACK;
              rleft_nxt       = rleft_r - 8'd1;
            end else begin
              res.bus_command = CMD_STOP;
              res.done_res    = 1'b1;
              phase_nxt       = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Advance the transaction state when an item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      wleft_r <= '0;
      rleft_r <= '0;
      probe_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      wleft_r <= wleft_nxt;
      rleft_r <= rleft_nxt;
      probe_r <= probe_nxt;
    end
  end

endmodule

>>> hdl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer. Each transfer on the input stream (begin request,
// next write byte, or bus-step completion from the byte engine) yields exactly one
// result transfer carrying the next bus command, any received byte, a request for
// the next write byte, and on completion a done flag with result code. An item is
// held in an input register, decided by one pass of next-state logic against the
// transaction state, and lands in an output register: one item per clock cycle is
// sustained while out_tready does not stall the output, and the input keeps
// accepting while a result waits as long as the output register frees in that cycle.
module i2c_master_transaction_sequencer #(
  parameter int MAX_COUNT = i2cmts_pkg::MAX_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_address[6:0], write_count[14:7], read_count[22:15], address_only[23],
  // write_byte[31:24], status_code[39:32], rx_data[47:40]
  input  logic [47:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte[7:0], rx_byte[15:8], rx_valid[16], need_write_byte[17], done_res[18],
  // result_code[21:19], zero fill[23:22]
  output logic [23:0] out_tdata,
  // bus_command[2:0]
  output logic [2:0]  out_tuser
);
  import i2cmts_pkg::*;

  logic  in_valid_r;
  item_t item_r;
  logic  out_valid_r;
  res_t  res_r;
  res_t  res;
  logic  fire;

  // Move the held item to the output when the output register is free
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!in_valid_r || fire);

  // Hold the accepted input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= {in_tdata, in_tuser};
    end
  end

  i2cmts_core #(
    .MAX_COUNT (MAX_COUNT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // Register the result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.bus_command;
  assign out_tdata  = {2'b00, res_r.result_code, res_r.done_res, res_r.need_write_byte,
                       res_r.rx_valid, res_r.rx_byte, res_r.tx_byte};

endmodule
